@@ rtl/rar3lz_pkg.sv @@
// Shared types, codes and symbol tables for the RAR 3.x LZ token resolver.
package rar3lz_pkg;

  // Repeated align value count after an align escape symbol.
  localparam logic [3:0] ALIGN_REPEAT = 4'd15;

  localparam logic [8:0] SYM_END_BLOCK   = 9'd256;
  localparam logic [8:0] SYM_FILTER      = 9'd257;
  localparam logic [8:0] SYM_REPEAT_LAST = 9'd258;
  localparam logic [8:0] SYM_REP_DIST1   = 9'd260;
  localparam logic [8:0] SYM_REP_DIST2   = 9'd261;
  localparam logic [8:0] SYM_SHORT       = 9'd263;
  localparam logic [8:0] SYM_FULL        = 9'd271;
  localparam logic [8:0] SYM_LIMIT       = 9'd299;

  localparam logic [5:0] LEN_SYM_LIMIT  = 6'd28;
  localparam logic [5:0] DIST_SYM_LIMIT = 6'd60;
  localparam logic [5:0] DIST_SYM_ALIGN = 6'd10;
  localparam logic [4:0] ALIGN_ESCAPE   = 5'd16;

  localparam logic [21:0] BONUS_LIMIT_A = 22'h001FFE;
  localparam logic [21:0] BONUS_LIMIT_B = 22'h03FFFE;

  typedef enum logic [1:0] {
    KIND_TOKEN      = 2'd0,
    KIND_NEW_TABLES = 2'd1,
    KIND_NEW_STREAM = 2'd2,
    KIND_RESERVED   = 2'd3
  } in_kind_t;

  typedef enum logic [2:0] {
    RES_LITERAL    = 3'd0,
    RES_MATCH      = 3'd1,
    RES_END_BLOCK  = 3'd2,
    RES_FILTER     = 3'd3,
    RES_ERROR      = 3'd4,
    RES_RESET_DONE = 3'd5
  } res_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_MAIN   = 3'd1,
    ERR_LENGTH = 3'd2,
    ERR_DIST   = 3'd3,
    ERR_ALIGN  = 3'd4,
    ERR_BEYOND = 3'd5
  } err_code_t;

  typedef struct packed {
    in_kind_t    kind;
    logic [8:0]  main_symbol;
    logic [5:0]  len_symbol;
    logic [4:0]  len_extra;
    logic [5:0]  dist_symbol;
    logic [13:0] dist_extra;
    logic [4:0]  align_symbol;
  } token_t;

  typedef struct packed {
    logic [3:0][22:0] rep;
    logic [8:0]       prev_len;
    logic [3:0]       abits;
    logic [3:0]       acount;
    logic [31:0]      bytes;
  } hist_t;

  typedef struct packed {
    res_kind_t   result_kind;
    logic [7:0]  literal;
    logic [22:0] distance;
    logic [8:0]  length;
    logic        align_used;
    err_code_t   error_code;
  } result_t;

  // Length base for slots 0-27: linear below 8, then four slots per doubling.
  function automatic logic [7:0] len_base(input logic [4:0] k);
    logic [7:0] b;
    if (k < 5'd8) begin
      b = {3'b000, k};
    end else begin
      b = {5'b00000, 1'b1, k[1:0]} << (k[4:2] - 3'd1);
    end
    return b;
  endfunction

  function automatic logic [2:0] len_bits(input logic [4:0] k);
    logic [2:0] n;
    if (k < 5'd8) begin
      n = 3'd0;
    end else begin
      n = k[4:2] - 3'd1;
    end
    return n;
  endfunction

  function automatic logic [4:0] dist_bits(input logic [5:0] ds);
    logic [4:0] n;
    if (ds < 6'd4) begin
      n = 5'd0;
    end else if (ds < 6'd34) begin
      n = ds[5:1] - 5'd1;
    end else if (ds < 6'd48) begin
      n = 5'd16;
    end else begin
      n = 5'd18;
    end
    return n;
  endfunction

  // Running sum of the slot sizes, written in closed form per region.
  function automatic logic [21:0] dist_base(input logic [5:0] ds);
    logic [21:0] b;
    if (ds < 6'd4) begin
      b = {16'd0, ds};
    end else if (ds < 6'd34) begin
      b = {20'd0, 1'b1, ds[0]} << (ds[5:1] - 5'd1);
    end else if (ds < 6'd48) begin
      b = 22'd131072 + ({18'd0, 4'(ds - 6'd34)} << 16);
    end else begin
      b = 22'd1048576 + ({18'd0, 4'(ds - 6'd48)} << 18);
    end
    return b;
  endfunction

  function automatic logic [7:0] short_base(input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0: b = 8'd0;
      3'd1: b = 8'd4;
      3'd2: b = 8'd8;
      3'd3: b = 8'd16;
      3'd4: b = 8'd32;
      3'd5: b = 8'd64;
      3'd6: b = 8'd128;
      3'd7: b = 8'd192;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] short_bits(input logic [2:0] k);
    logic [2:0] n;
    unique case (k)
      3'd0, 3'd1: n = 3'd2;
      3'd2: n = 3'd3;
      3'd3: n = 3'd4;
      3'd4: n = 3'd5;
      3'd5, 3'd6, 3'd7: n = 3'd6;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] low5(input logic [4:0] v, input logic [2:0] n);
    logic [4:0] m;
    m = ~(5'h1F << n);
    return v & m;
  endfunction

  function automatic logic [13:0] low14(input logic [13:0] v, input logic [3:0] n);
    logic [13:0] m;
    m = ~(14'h3FFF << n);
    return v & m;
  endfunction

endpackage

@@ rtl/rar3lz_resolve.sv @@
// Token resolver: decode history registers and the single-pass resolve logic.
module rar3lz_resolve (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  rar3lz_pkg::token_t  tok,
  output rar3lz_pkg::result_t res,
  output logic              has_result
);
  import rar3lz_pkg::*;

  hist_t            cur;
  hist_t            nxt;
  logic [3:0][22:0] r;
  logic [8:0]       len;
  logic [3:0]       abits;
  logic [3:0]       acount;
  logic             aused;
  err_code_t        err;
  logic [21:0]      dfull;
  logic [4:0]       nb;
  logic [4:0]       k5;
  logic [2:0]       k3;
  logic [8:0]       inc;
  logic             add_en;
  logic [32:0]      sum;

  always_comb begin
    nxt        = cur;
    res        = '0;
    has_result = 1'b1;
    r          = cur.rep;
    len        = cur.prev_len;
    abits      = cur.abits;
    acount     = cur.acount;
    aused      = 1'b0;
    err        = ERR_NONE;
    dfull      = '0;
    nb         = '0;
    k5         = 5'(tok.main_symbol - SYM_FULL);
    k3         = 3'(tok.main_symbol - SYM_SHORT);
    inc        = '0;
    add_en     = 1'b0;

    unique case (tok.kind)
      KIND_NEW_STREAM: begin
        res.result_kind = RES_RESET_DONE;
        nxt = '0;
      end
      KIND_NEW_TABLES: begin
        res.result_kind = RES_RESET_DONE;
        nxt.abits  = '0;
        nxt.acount = '0;
      end
      KIND_RESERVED: begin
        has_result = 1'b0;
      end
      KIND_TOKEN: begin
        if (!tok.main_symbol[8]) begin
          res.result_kind = RES_LITERAL;
          res.literal     = tok.main_symbol[7:0];
          inc    = 9'd1;
          add_en = 1'b1;
        end else if (tok.main_symbol == SYM_END_BLOCK) begin
          res.result_kind = RES_END_BLOCK;
        end else if (tok.main_symbol == SYM_FILTER) begin
          res.result_kind = RES_FILTER;
        end else begin
          priority if (tok.main_symbol == SYM_REPEAT_LAST) begin
            // Same distance and length as the last match.
          end else if (tok.main_symbol < SYM_SHORT) begin
            // Move the chosen repeat distance to the front.
            if (tok.main_symbol == SYM_REP_DIST1) begin
              r[0] = cur.rep[1];
              r[1] = cur.rep[0];
            end else if (tok.main_symbol == SYM_REP_DIST2) begin
              r[0] = cur.rep[2];
              r[1] = cur.rep[0];
              r[2] = cur.rep[1];
            end else if (tok.main_symbol != SYM_REPEAT_LAST + 9'd1) begin
              r[0] = cur.rep[3];
              r[1] = cur.rep[0];
              r[2] = cur.rep[1];
              r[3] = cur.rep[2];
            end
            if (tok.len_symbol >= LEN_SYM_LIMIT) begin
              err = ERR_LENGTH;
            end else begin
              len = 9'd2 + 9'(len_base(tok.len_symbol[4:0]))
                  + 9'(low5(tok.len_extra, len_bits(tok.len_symbol[4:0])));
            end
          end else if (tok.main_symbol < SYM_FULL) begin
            r[3] = cur.rep[2];
            r[2] = cur.rep[1];
            r[1] = cur.rep[0];
            r[0] = 23'(short_base(k3))
                 + 23'(low14(tok.dist_extra, {1'b0, short_bits(k3)}));
            len  = 9'd2;
          end else if (tok.main_symbol < SYM_LIMIT) begin
            r[3] = cur.rep[2];
            r[2] = cur.rep[1];
            r[1] = cur.rep[0];
            len  = 9'd3 + 9'(len_base(k5)) + 9'(low5(tok.len_extra, len_bits(k5)));
            if (tok.dist_symbol >= DIST_SYM_LIMIT) begin
              err = ERR_DIST;
            end else begin
              nb    = dist_bits(tok.dist_symbol);
              dfull = dist_base(tok.dist_symbol);
              if (tok.dist_symbol >= DIST_SYM_ALIGN) begin
                // Far distances take their low four bits from the align code.
                dfull = dfull + ({8'd0, low14(tok.dist_extra, 4'(nb - 5'd4))} << 4);
                if (acount != 4'd0) begin
                  acount = acount - 4'd1;
                  dfull  = dfull + {18'd0, abits};
                end else begin
                  aused = 1'b1;
                  if (tok.align_symbol < ALIGN_ESCAPE) begin
                    dfull = dfull + {18'd0, tok.align_symbol[3:0]};
                    abits = tok.align_symbol[3:0];
                  end else if (tok.align_symbol == ALIGN_ESCAPE) begin
                    acount = ALIGN_REPEAT;
                    dfull  = dfull + {18'd0, abits};
                  end else begin
                    err = ERR_ALIGN;
                  end
                end
              end else begin
                dfull = dfull + {8'd0, low14(tok.dist_extra, nb[3:0])};
              end
              if (err == ERR_NONE) begin
                if (dfull > BONUS_LIMIT_B) begin
                  len = len + 9'd1;
                end
                if (dfull > BONUS_LIMIT_A) begin
                  len = len + 9'd1;
                end
              end
              r[0] = {1'b0, dfull};
            end
          end else begin
            err = ERR_MAIN;
          end

          if (err == ERR_NONE && {9'd0, r[0]} >= cur.bytes) begin
            err = ERR_BEYOND;
          end

          res.align_used = aused;
          if (err != ERR_NONE) begin
            res.result_kind = RES_ERROR;
            res.error_code  = err;
          end else begin
            res.result_kind = RES_MATCH;
            res.distance    = r[0];
            res.length      = len;
            nxt.rep      = r;
            nxt.prev_len = len;
            nxt.abits    = abits;
            nxt.acount   = acount;
            inc    = len;
            add_en = 1'b1;
          end
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase

    // The byte count saturates instead of wrapping.
    sum = {1'b0, cur.bytes} + {24'd0, inc};
    if (add_en) begin
      nxt.bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (fire) begin
      cur <= nxt;
    end
  end

  a_stream_clears: assert property (@(posedge clk) disable iff (rst)
    fire && tok.kind == KIND_NEW_STREAM |=> cur.bytes == '0 && cur.rep == '0)
    else $error("new stream item did not clear the decode history");

  a_bytes_monotonic: assert property (@(posedge clk) disable iff (rst)
    fire && tok.kind != KIND_NEW_STREAM |=> cur.bytes >= $past(cur.bytes))
    else $error("byte count went down without a new stream");

  a_error_keeps_state: assert property (@(posedge clk) disable iff (rst)
    fire && has_result && res.result_kind == RES_ERROR |=> cur == $past(cur))
    else $error("an error item changed the decode history");

  a_match_in_window: assert property (@(posedge clk) disable iff (rst)
    fire && res.result_kind == RES_MATCH |-> {9'd0, res.distance} < cur.bytes)
    else $error("match reaches back beyond the produced output");

endmodule

@@ rtl/rar3lz_out_stage.sv @@
// Result register that holds one resolved item until the consumer takes it.
module rar3lz_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rar3lz_pkg::result_t din,
  input  logic              ready,
  output logic              valid,
  output rar3lz_pkg::result_t dout
);
  import rar3lz_pkg::*;

  result_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

@@ rtl/rar3_lz_token_resolver.sv @@
// Top level of the RAR 3.x LZ token resolver: token register, resolver, result register.
//
// Each accepted item is one decoded token and yields at most one result: a literal, a
// (distance minus one, length) match, an end-of-block or filter-code mark, a reset
// acknowledge for the new-tables and new-stream kinds, or an error with its code; kind 3
// yields nothing. The block sustains one item per clock unless the consumer stalls. An item
// sits in the token register, is resolved in a single pass against the repeat distances, last
// length, align state and saturating byte count, and its result is loaded into the
// result register when the item moves on and held there until taken, so a result waits
// in the result register while the next item can already be accepted. The clock period
// is set by that single pass: the distance base, extra and align add followed by the
// 32-bit compare with the byte count.
// Errors leave all history unchanged. There is no clearing pass after reset.
module rar3_lz_token_resolver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [8:0]  main_symbol,
  input  logic [5:0]  len_symbol,
  input  logic [4:0]  len_extra,
  input  logic [5:0]  dist_symbol,
  input  logic [13:0] dist_extra,
  input  logic [4:0]  align_symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  literal,
  output logic [22:0] distance,
  output logic [8:0]  length,
  output logic        align_used,
  output logic [2:0]  error_code
);
  import rar3lz_pkg::*;

  token_t  tok_q;
  logic    in_full;
  logic    fire;
  logic    has_result;
  result_t res;
  result_t out_res;

  // The held item moves on when its result has room, or when it makes no result.
  assign fire     = in_full && (!has_result || !out_valid || out_ready);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok_q.kind         <= in_kind_t'(kind);
      tok_q.main_symbol  <= main_symbol;
      tok_q.len_symbol   <= len_symbol;
      tok_q.len_extra    <= len_extra;
      tok_q.dist_symbol  <= dist_symbol;
      tok_q.dist_extra   <= dist_extra;
      tok_q.align_symbol <= align_symbol;
    end
  end

  rar3lz_resolve u_resolve (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .tok        (tok_q),
    .res        (res),
    .has_result (has_result)
  );

  rar3lz_out_stage u_out_stage (
    .clk   (clk),
    .rst   (rst),
    .load  (fire && has_result),
    .din   (res),
    .ready (out_ready),
    .valid (out_valid),
    .dout  (out_res)
  );

  assign result_kind = out_res.result_kind;
  assign literal     = out_res.literal;
  assign distance    = out_res.distance;
  assign length      = out_res.length;
  assign align_used  = out_res.align_used;
  assign error_code  = out_res.error_code;

endmodule

@@ tb/rar3_lz_token_resolver_checker.sv @@
// Checker for the LZ token resolver: predicts each result from the accepted tokens and compares.
module rar3_lz_token_resolver_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [8:0]  main_symbol,
  input  logic [5:0]  len_symbol,
  input  logic [4:0]  len_extra,
  input  logic [5:0]  dist_symbol,
  input  logic [13:0] dist_extra,
  input  logic [4:0]  align_symbol,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  result_kind,
  input  logic [7:0]  literal,
  input  logic [22:0] distance,
  input  logic [8:0]  length,
  input  logic        align_used,
  input  logic [2:0]  error_code,
  output int          fail_count,
  output int          pending,
  output int          match_count,
  output int          error_count
);
  import rar3lz_pkg::*;

  localparam logic [8:0] SYM_REP_DIST0 = SYM_REPEAT_LAST + 9'd1;
  localparam int unsigned ALIGN_BITS = 4;

  // Length slot bases, slot 0 in the low byte.
  localparam logic [223:0] LEN_BASE_V = {
    8'd224, 8'd192, 8'd160, 8'd128, 8'd112, 8'd96, 8'd80, 8'd64,
    8'd56, 8'd48, 8'd40, 8'd32, 8'd28, 8'd24, 8'd20, 8'd16,
    8'd14, 8'd12, 8'd10, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};
  localparam logic [63:0] SHORT_BASE_V = {
    8'd192, 8'd128, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd0};
  localparam logic [23:0] SHORT_BITS_V = {
    3'd6, 3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2};

  logic [31:0] dist_base_tab [0:59];
  logic [31:0] dist_bits_tab [0:59];

  // History as the decoder sees it.
  logic [31:0] rep_dist [0:3];
  logic [8:0]  last_len;
  logic [3:0]  align_low;
  logic [3:0]  align_left;
  logic [31:0] out_bytes;

  result_t expected_results [$];
  int fail_cnt = 0;
  int match_cnt = 0;
  int error_cnt = 0;
  int pend_cnt = 0;

  assign fail_count = fail_cnt;
  assign pending = pend_cnt;
  assign match_count = match_cnt;
  assign error_count = error_cnt;

  // Distance slots grow by two per doubling, then run flat at 16 and 18 bits.
  initial begin : build_dist_tables
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < DIST_SYM_LIMIT; i++) begin
      if (i < 4) begin
        dist_bits_tab[i] = 0;
      end else if (i < 34) begin
        dist_bits_tab[i] = i / 2 - 1;
      end else if (i < 48) begin
        dist_bits_tab[i] = 16;
      end else begin
        dist_bits_tab[i] = 18;
      end
      dist_base_tab[i] = acc;
      acc = acc + (32'd1 << dist_bits_tab[i]);
    end
  end

  function automatic logic [31:0] lowmask(input logic [31:0] n);
    return (32'd1 << n) - 32'd1;
  endfunction

  function automatic logic [31:0] slot_len_bits(input logic [31:0] k);
    return (k < 32'd8) ? 32'd0 : (k / 32'd4 - 32'd1);
  endfunction

  function automatic logic [31:0] slot_len(input logic [31:0] k, input logic [4:0] extra);
    return {24'd0, LEN_BASE_V[k*8 +: 8]} + ({27'd0, extra} & lowmask(slot_len_bits(k)));
  endfunction

  task automatic clear_history();
    for (int i = 0; i < 4; i++) rep_dist[i] = '0;
    last_len = '0;
    align_low = '0;
    align_left = '0;
    out_bytes = '0;
  endtask

  task automatic grow_bytes(input logic [31:0] n);
    logic [32:0] t;
    t = {1'b0, out_bytes} + {1'b0, n};
    out_bytes = t[32] ? 32'hFFFF_FFFF : t[31:0];
  endtask

  task automatic resolve_token(input logic [1:0] k, input logic [8:0] sym,
                               input logic [5:0] ls, input logic [4:0] le,
                               input logic [5:0] ds, input logic [13:0] de,
                               input logic [4:0] asym, output bit produced,
                               output result_t res);
    logic [31:0] r0, r1, r2, r3, d, len, abits, acount, nb, idx;
    bit aused;
    err_code_t err;
    res = '0;
    produced = 1'b1;
    aused = 1'b0;
    err = ERR_NONE;
    r0 = rep_dist[0];
    r1 = rep_dist[1];
    r2 = rep_dist[2];
    r3 = rep_dist[3];
    len = {23'd0, last_len};
    abits = {28'd0, align_low};
    acount = {28'd0, align_left};
    if (k == KIND_RESERVED) begin
      produced = 1'b0;
    end else if (k == KIND_NEW_STREAM) begin
      clear_history();
      res.result_kind = RES_RESET_DONE;
    end else if (k == KIND_NEW_TABLES) begin
      align_low = '0;
      align_left = '0;
      res.result_kind = RES_RESET_DONE;
    end else if (sym < SYM_END_BLOCK) begin
      res.result_kind = RES_LITERAL;
      res.literal = sym[7:0];
      grow_bytes(32'd1);
    end else if (sym == SYM_END_BLOCK) begin
      res.result_kind = RES_END_BLOCK;
    end else if (sym == SYM_FILTER) begin
      res.result_kind = RES_FILTER;
    end else begin
      if (sym == SYM_REPEAT_LAST) begin
        // Same distance and length as the previous match.
      end else if (sym < SYM_SHORT) begin
        // The chosen repeat distance moves to the front.
        if (sym != SYM_REP_DIST0) begin
          if (sym == SYM_REP_DIST1) begin
            d = r1;
          end else begin
            if (sym == SYM_REP_DIST2) begin
              d = r2;
            end else begin
              d = r3;
              r3 = r2;
            end
            r2 = r1;
          end
          r1 = r0;
          r0 = d;
        end
        if (ls >= LEN_SYM_LIMIT) begin
          err = ERR_LENGTH;
        end else begin
          len = 32'd2 + slot_len({26'd0, ls}, le);
        end
      end else if (sym < SYM_FULL) begin
        idx = {23'd0, sym - SYM_SHORT};
        r3 = r2;
        r2 = r1;
        r1 = r0;
        r0 = {24'd0, SHORT_BASE_V[idx*8 +: 8]} +
             ({18'd0, de} & lowmask({29'd0, SHORT_BITS_V[idx*3 +: 3]}));
        len = 32'd2;
      end else if (sym < SYM_LIMIT) begin
        idx = {23'd0, sym - SYM_FULL};
        r3 = r2;
        r2 = r1;
        r1 = r0;
        len = 32'd3 + slot_len(idx, le);
        if (ds >= DIST_SYM_LIMIT) begin
          err = ERR_DIST;
        end else begin
          nb = dist_bits_tab[ds];
          r0 = dist_base_tab[ds];
          if (ds >= DIST_SYM_ALIGN) begin
            // Extra bits cover the distance above the align field.
            if (nb > ALIGN_BITS) r0 = r0 + (({18'd0, de} & lowmask(nb - ALIGN_BITS)) << ALIGN_BITS);
            if (acount > 32'd0) begin
              acount = acount - 32'd1;
              r0 = r0 + abits;
            end else begin
              aused = 1'b1;
              if (asym < ALIGN_ESCAPE) begin
                r0 = r0 + {27'd0, asym};
                abits = {27'd0, asym};
              end else if (asym == ALIGN_ESCAPE) begin
                acount = {28'd0, ALIGN_REPEAT};
                r0 = r0 + abits;
              end else begin
                err = ERR_ALIGN;
              end
            end
          end else begin
            r0 = r0 + ({18'd0, de} & lowmask(nb));
          end
          if (err == ERR_NONE) begin
            if (r0 > {10'd0, BONUS_LIMIT_B}) len = len + 32'd1;
            if (r0 > {10'd0, BONUS_LIMIT_A}) len = len + 32'd1;
          end
        end
      end else begin
        err = ERR_MAIN;
      end
      if (err == ERR_NONE && r0 >= out_bytes) err = ERR_BEYOND;
      res.align_used = aused;
      if (err != ERR_NONE) begin
        res.result_kind = RES_ERROR;
        res.error_code = err;
      end else begin
        rep_dist[0] = r0;
        rep_dist[1] = r1;
        rep_dist[2] = r2;
        rep_dist[3] = r3;
        last_len = len[8:0];
        align_low = abits[3:0];
        align_left = acount[3:0];
        grow_bytes({23'd0, len[8:0]});
        res.result_kind = RES_MATCH;
        res.distance = r0[22:0];
        res.length = len[8:0];
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    bit got;
    result_t res;
    result_t want;
    if (rst) begin
      clear_history();
      expected_results.delete();
      pend_cnt <= 0;
    end else begin
      if (in_valid && in_ready) begin
        resolve_token(kind, main_symbol, len_symbol, len_extra, dist_symbol, dist_extra,
                      align_symbol, got, res);
        if (got) expected_results.insert(expected_results.size(), res);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result kind %0d arrived with nothing expected", $time, result_kind);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(result_kind));
          check_field("literal", 32'(want.literal), 32'(literal));
          check_field("distance", 32'(want.distance), 32'(distance));
          check_field("length", 32'(want.length), 32'(length));
          check_field("align_used", 32'(want.align_used), 32'(align_used));
          check_field("error_code", 32'(want.error_code), 32'(error_code));
          if (want.result_kind == RES_MATCH) match_cnt++;
          if (want.result_kind == RES_ERROR) error_cnt++;
        end
      end
      pend_cnt <= expected_results.size();
    end
  end

endmodule

@@ tb/tb_rar3_lz_token_resolver.sv @@
// Testbench top for the LZ token resolver: clock, reset, token stimulus and the verdict.
module tb_rar3_lz_token_resolver;
  import rar3lz_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REPEAT_RUN = 40;
  localparam int STREAM_ITEMS = 240;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [8:0]  main_symbol;
  logic [5:0]  len_symbol;
  logic [4:0]  len_extra;
  logic [5:0]  dist_symbol;
  logic [13:0] dist_extra;
  logic [4:0]  align_symbol;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  result_kind;
  logic [7:0]  literal;
  logic [22:0] distance;
  logic [8:0]  length;
  logic        align_used;
  logic [2:0]  error_code;

  int fail_count;
  int pending;
  int match_count;
  int error_count;
  int cycles = 0;
  int items_sent = 0;
  int in_burst_left = 0;
  int out_burst_left = 0;
  bit in_no_gap;
  bit out_no_gap;

  always #10 clk = ~clk;

  rar3_lz_token_resolver u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .main_symbol(main_symbol), .len_symbol(len_symbol), .len_extra(len_extra),
    .dist_symbol(dist_symbol), .dist_extra(dist_extra), .align_symbol(align_symbol),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .literal(literal), .distance(distance), .length(length), .align_used(align_used),
    .error_code(error_code)
  );

  rar3_lz_token_resolver_checker u_check (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .main_symbol(main_symbol), .len_symbol(len_symbol), .len_extra(len_extra),
    .dist_symbol(dist_symbol), .dist_extra(dist_extra), .align_symbol(align_symbol),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .literal(literal), .distance(distance), .length(length), .align_used(align_used),
    .error_code(error_code), .fail_count(fail_count), .pending(pending),
    .match_count(match_count), .error_count(error_count)
  );

  task automatic send_item(input logic [1:0] k, input logic [8:0] ms, input logic [5:0] ls,
                           input logic [4:0] le, input logic [5:0] ds,
                           input logic [13:0] de, input logic [4:0] asym);
    int gap;
    if (in_burst_left == 0) begin
      in_burst_left = $urandom_range(16, 64);
      in_no_gap = ($urandom_range(0, 3) == 0);
    end
    in_burst_left--;
    gap = in_no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind <= k;
    main_symbol <= ms;
    len_symbol <= ls;
    len_extra <= le;
    dist_symbol <= ds;
    dist_extra <= de;
    align_symbol <= asym;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (k != KIND_RESERVED) items_sent++;
  endtask

  // Mostly well-formed tokens; cap bounds the distance slot so matches stay inside the output.
  task automatic random_token(input int cap);
    int pick;
    logic [1:0]  k;
    logic [8:0]  ms;
    logic [5:0]  ls;
    logic [4:0]  le;
    logic [5:0]  ds;
    logic [13:0] de;
    logic [4:0]  asym;
    k = KIND_TOKEN;
    ls = 6'($urandom_range(0, LEN_SYM_LIMIT - 1));
    le = 5'($urandom);
    ds = 6'($urandom_range(0, cap));
    de = 14'($urandom);
    asym = 5'($urandom_range(0, ALIGN_ESCAPE));
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      ms = 9'($urandom_range(0, SYM_END_BLOCK - 1));
    end else if (pick < 33) begin
      ms = SYM_REPEAT_LAST;
    end else if (pick < 48) begin
      ms = 9'($urandom_range(SYM_REPEAT_LAST + 1, SYM_SHORT - 1));
      if ($urandom_range(0, 15) == 0) ls = 6'($urandom_range(LEN_SYM_LIMIT, 63));
    end else if (pick < 60) begin
      ms = 9'($urandom_range(SYM_SHORT, SYM_FULL - 1));
    end else if (pick < 86) begin
      ms = 9'($urandom_range(SYM_FULL, SYM_LIMIT - 1));
      if ($urandom_range(0, 19) == 0) ds = 6'($urandom_range(DIST_SYM_LIMIT, 63));
      if ($urandom_range(0, 19) == 0) asym = 5'($urandom_range(ALIGN_ESCAPE + 1, 31));
    end else if (pick < 89) begin
      ms = 9'($urandom_range(SYM_END_BLOCK, SYM_FILTER));
    end else begin
      // Noise: any field value at all.
      ms = 9'($urandom);
      ls = 6'($urandom);
      ds = 6'($urandom);
      asym = 5'($urandom);
      if (pick == 89) k = KIND_NEW_TABLES;
      if (pick == 90 || pick == 91) k = KIND_RESERVED;
      if (pick == 92 && $urandom_range(0, 3) == 0) k = KIND_NEW_STREAM;
    end
    send_item(k, ms, ls, le, ds, de, asym);
  endtask

  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_burst_left == 0) begin
        out_burst_left = $urandom_range(16, 64);
        out_no_gap = ($urandom_range(0, 3) == 0);
      end
      out_burst_left--;
      stall = out_no_gap ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles without draining.", cycles);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int cap;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_TOKEN;
    main_symbol <= '0;
    len_symbol <= '0;
    len_extra <= '0;
    dist_symbol <= '0;
    dist_extra <= '0;
    align_symbol <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed tokens: every symbol class, the error codes and the align escape.
    send_item(KIND_NEW_STREAM, '0, '0, '0, '0, '0, '0);
    send_item(KIND_RESERVED, 9'h1FF, 6'h3F, 5'h1F, 6'h3F, 14'h3FFF, 5'h1F);
    send_item(KIND_TOKEN, SYM_REPEAT_LAST, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, 9'd0, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, 9'd255, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_END_BLOCK, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_FILTER, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_LIMIT, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, 9'h1FF, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_SHORT, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_LIMIT - 9'd1, '0, 5'd31, 6'd3, '0, '0);
    send_item(KIND_TOKEN, SYM_REPEAT_LAST + 9'd1, LEN_SYM_LIMIT - 6'd1, 5'd31, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_REP_DIST1, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_REP_DIST2, 6'd8, 5'd1, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_SHORT - 9'd1, LEN_SYM_LIMIT, '0, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_SHORT - 9'd1, 6'd63, 5'd31, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_FULL - 9'd1, '0, '0, '0, 14'h3FFF, '0);
    send_item(KIND_TOKEN, SYM_FULL, '0, '0, DIST_SYM_LIMIT, '0, '0);
    send_item(KIND_TOKEN, SYM_FULL, '0, '0, 6'd63, '0, '0);
    send_item(KIND_TOKEN, 9'd280, '0, '0, 6'd12, '0, ALIGN_ESCAPE + 5'd1);
    send_item(KIND_TOKEN, 9'd280, '0, '0, 6'd12, 14'd1, ALIGN_ESCAPE);
    send_item(KIND_TOKEN, 9'd280, '0, '0, 6'd13, '0, 5'd5);
    send_item(KIND_NEW_TABLES, '0, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, 9'd290, '0, '0, DIST_SYM_ALIGN, 14'h3FFF, 5'd15);
    send_item(KIND_TOKEN, SYM_REPEAT_LAST, '0, '0, '0, '0, '0);
    send_item(KIND_TOKEN, SYM_LIMIT - 9'd1, '0, '0, DIST_SYM_LIMIT - 6'd1, 14'h3FFF, '0);

    // Three streams of random tokens; the middle one first builds a longer output
    // so that far distances with the first length bonus become legal.
    for (int s = 0; s < 3; s++) begin
      send_item(KIND_NEW_STREAM, 9'($urandom), 6'($urandom), 5'($urandom), 6'($urandom),
                14'($urandom), 5'($urandom));
      if (s == 1) begin
        repeat (8) send_item(KIND_TOKEN, 9'($urandom_range(0, 255)), '0, '0, '0, '0, '0);
        send_item(KIND_TOKEN, SYM_LIMIT - 9'd1, '0, 5'd31, '0, '0, '0);
        repeat (REPEAT_RUN) send_item(KIND_TOKEN, SYM_REPEAT_LAST, '0, '0, '0, '0, '0);
      end
      for (int n = 0; n < STREAM_ITEMS; n++) begin
        if (s == 1) begin
          cap = 29;
        end else if (n < 40) begin
          cap = 11;
        end else if (n < 150) begin
          cap = 21;
        end else begin
          cap = 27;
        end
        random_token(cap);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d tokens over three streams, one with a run of %0d repeated matches.",
             items_sent, REPEAT_RUN);
    $display("Checked %0d match results and %0d error results.", match_count, error_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
